// ----- rtl/core/apmq_pkg.sv -----
package apmq_pkg;

    localparam int MSG_W   = 32;
    localparam int QSIZE_W = 5;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    localparam logic MK_NORMAL = 1'b0;
    localparam logic MK_ALARM  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_NO_MSG  = 2'd2
    } status_t;

    // result waiting to go to the output stage
    typedef struct packed {
        status_t              status;
        logic                 kind_out;
        logic [QSIZE_W-1:0]   queue_size;
        logic                 alarm_count;
        logic                 from_ram;     // word comes from the FIFO memory read
        logic [MSG_W-1:0]     message_out;  // alarm word or zero
    } result_t;

endpackage

// ----- rtl/core/alarm_priority_message_queue_core.sv -----
// channel  | ports                                   | direction
// ---------+-----------------------------------------+----------
// input    | s_valid s_ready s_kind s_msg_kind       | in
//          | s_message                               |
// result   | m_valid m_ready m_status m_message_out  | out
//          | m_kind_out m_queue_size m_alarm_count   |
//
// An item is decided in its accept cycle; its result sits in a pending stage
// and moves to the output register when the output stage is free; no new
// item is taken while a result is pending. A normal receive reads the FIFO
// memory in the accept cycle; the registered read data is picked up by the
// output stage. A stalled output holds the pending result and blocks s_ready.
// Synchronous active-low reset empties the queue; no memory clearing pass.
module alarm_priority_message_queue_core #(
    parameter int FIFO_DEPTH    = 16,
    parameter int MESSAGE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic        s_msg_kind,
    input  logic [31:0] s_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_message_out,
    output logic        m_kind_out,
    output logic [4:0]  m_queue_size,
    output logic        m_alarm_count
);

    localparam int AW = $clog2(FIFO_DEPTH);

    logic                     ram_we, ram_re;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [MESSAGE_WIDTH-1:0] ram_wdata, ram_rdata;
    logic                     pend_valid, take;
    apmq_pkg::result_t        pend;
    logic [63:0]              rd_wide;

    logic                            out_valid_reg;
    apmq_pkg::status_t               out_status_reg;
    logic [apmq_pkg::MSG_W-1:0]      out_msg_reg;
    logic                            out_kind_reg;
    logic [apmq_pkg::QSIZE_W-1:0]    out_size_reg;
    logic                            out_alarm_reg;

    apmq_ctrl #(
        .FIFO_DEPTH   (FIFO_DEPTH),
        .MESSAGE_WIDTH(MESSAGE_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .op        (s_kind),
        .msg_kind  (s_msg_kind),
        .message   (s_message),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .pend_valid(pend_valid),
        .pend      (pend),
        .pend_take (take)
    );

    apmq_ram #(
        .WIDTH(MESSAGE_WIDTH),
        .DEPTH(FIFO_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign take    = pend_valid && (!out_valid_reg || m_ready);
    assign rd_wide = 64'(ram_rdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_status_reg <= pend.status;
            out_msg_reg    <= pend.from_ram ? rd_wide[apmq_pkg::MSG_W-1:0] : pend.message_out;
            out_kind_reg   <= pend.kind_out;
            out_size_reg   <= pend.queue_size;
            out_alarm_reg  <= pend.alarm_count;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_message_out = out_msg_reg;
    assign m_kind_out    = out_kind_reg;
    assign m_queue_size  = out_size_reg;
    assign m_alarm_count = out_alarm_reg;

`ifndef SYNTHESIS
    // pending stage takes one item at a time
    a_one_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a result was pending");

    a_no_msg_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == apmq_pkg::ST_NO_MSG |->
            m_message_out == '0 && !m_kind_out && m_queue_size == '0)
        else $error("empty receive returned data or nonzero size");

    // taking the alarm leaves the slot empty
    a_alarm_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind_out |-> !m_alarm_count && m_status == apmq_pkg::ST_OK)
        else $error("alarm receive left alarm slot occupied");
`endif

endmodule

// ----- rtl/core/apmq_ram.sv -----
module apmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/apmq_ctrl.sv -----
module apmq_ctrl #(
    parameter int FIFO_DEPTH    = 16,
    parameter int MESSAGE_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic                              msg_kind,
    input  logic [apmq_pkg::MSG_W-1:0]        message,
    output logic                              ram_we,
    output logic [$clog2(FIFO_DEPTH)-1:0]     ram_waddr,
    output logic [MESSAGE_WIDTH-1:0]          ram_wdata,
    output logic                              ram_re,
    output logic [$clog2(FIFO_DEPTH)-1:0]     ram_raddr,
    output logic                              pend_valid,
    output apmq_pkg::result_t                 pend,
    input  logic                              pend_take
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [AW-1:0]            rptr_reg, rptr_next;
    logic [AW-1:0]            wptr_reg, wptr_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     alarm_present_reg, alarm_present_next;
    logic [MESSAGE_WIDTH-1:0] alarm_word_reg;
    logic                     pend_valid_reg;
    apmq_pkg::result_t        pend_reg, res;

    logic                     accept;
    logic [63:0]              in_wide;
    logic [63:0]              alarm_wide;
    logic [CW:0]              size_full;
    logic [63:0]              size_wide;

    assign accept    = in_valid && !pend_valid_reg;
    assign in_ready  = !pend_valid_reg;
    assign in_wide   = {32'b0, message};
    assign alarm_wide = 64'(alarm_word_reg);

    assign ram_waddr = wptr_reg;
    assign ram_raddr = rptr_reg;
    assign ram_wdata = in_wide[MESSAGE_WIDTH-1:0];

    always_comb begin
        rptr_next          = rptr_reg;
        wptr_next          = wptr_reg;
        cnt_next           = cnt_reg;
        alarm_present_next = alarm_present_reg;
        ram_we             = 1'b0;
        ram_re             = 1'b0;
        res                = '0;
        res.status         = apmq_pkg::ST_OK;

        if (op == apmq_pkg::OP_SEND) begin
            if (msg_kind == apmq_pkg::MK_ALARM) begin
                if (alarm_present_reg) begin
                    res.status = apmq_pkg::ST_NO_ROOM;
                end else begin
                    alarm_present_next = 1'b1;
                end
            end else begin
                if (cnt_reg == CW'(FIFO_DEPTH)) begin
                    res.status = apmq_pkg::ST_NO_ROOM;
                end else begin
                    ram_we    = accept;
                    wptr_next = (wptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
        end else begin
            if (alarm_present_reg) begin
                res.message_out    = alarm_wide[apmq_pkg::MSG_W-1:0];
                res.kind_out       = 1'b1;
                alarm_present_next = 1'b0;
            end else if (cnt_reg != '0) begin
                ram_re       = accept;
                res.from_ram = 1'b1;
                rptr_next    = (rptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
                cnt_next     = cnt_reg - 1'b1;
            end else begin
                res.status = apmq_pkg::ST_NO_MSG;
            end
        end

        size_full       = {1'b0, cnt_next} + {{CW{1'b0}}, alarm_present_next};
        size_wide       = 64'(size_full);
        res.queue_size  = size_wide[apmq_pkg::QSIZE_W-1:0];
        res.alarm_count = alarm_present_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rptr_reg          <= '0;
            wptr_reg          <= '0;
            cnt_reg           <= '0;
            alarm_present_reg <= 1'b0;
            pend_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                rptr_reg          <= rptr_next;
                wptr_reg          <= wptr_next;
                cnt_reg           <= cnt_next;
                alarm_present_reg <= alarm_present_next;
                pend_valid_reg    <= 1'b1;
            end else if (pend_take) begin
                pend_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg <= res;
            if (op == apmq_pkg::OP_SEND && msg_kind == apmq_pkg::MK_ALARM
                && !alarm_present_reg) begin
                alarm_word_reg <= in_wide[MESSAGE_WIDTH-1:0];
            end
        end
    end

    assign pend_valid = pend_valid_reg;
    assign pend       = pend_reg;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

typedef struct {
    apmq_pkg::status_t status;
    logic [31:0]       word;
    logic              kind;
    logic [4:0]        size;
    logic              alarms;
} queue_reply_t;

class alarm_queue_scoreboard;
    localparam int DEPTH = 16;

    // predicted queue contents
    logic [31:0]  normal_words[$];
    logic [31:0]  alarm_word = '0;
    logic         alarm_held = 1'b0;
    queue_reply_t expected_replies[$];

    int errors = 0;
    int replies_seen = 0;
    int sends = 0;
    int receives = 0;
    int alarms_taken = 0;
    int alarm_refused = 0;
    int full_refused = 0;
    int empty_receives = 0;
    int peak_size = 0;

    function void note_request(logic kind, logic msg_kind, logic [31:0] message);
        queue_reply_t r;
        r.status = apmq_pkg::ST_OK;
        r.word   = '0;
        r.kind   = apmq_pkg::MK_NORMAL;
        if (kind == apmq_pkg::OP_SEND) begin
            sends++;
            if (msg_kind == apmq_pkg::MK_ALARM) begin
                if (alarm_held) begin
                    r.status = apmq_pkg::ST_NO_ROOM;
                    alarm_refused++;
                end else begin
                    alarm_word = message;
                    alarm_held = 1'b1;
                end
            end else if (normal_words.size() >= DEPTH) begin
                r.status = apmq_pkg::ST_NO_ROOM;
                full_refused++;
            end else begin
                normal_words.push_back(message);
            end
        end else begin
            receives++;
            if (alarm_held) begin
                // alarm always wins over older normal items
                r.word = alarm_word;
                r.kind = apmq_pkg::MK_ALARM;
                alarm_held = 1'b0;
                alarms_taken++;
            end else if (normal_words.size() > 0) begin
                r.word = normal_words.pop_front();
            end else begin
                r.status = apmq_pkg::ST_NO_MSG;
                empty_receives++;
            end
        end
        r.size   = 5'(normal_words.size() + (alarm_held ? 1 : 0));
        r.alarms = alarm_held;
        if (int'(r.size) > peak_size) peak_size = int'(r.size);
        expected_replies.push_back(r);
    endfunction

    function int pending();
        return expected_replies.size();
    endfunction

    function void report(string what, string exp_s, string got_s);
        errors++;
        if (errors <= 10)
            $display("[%0t] mismatch on reply %0d: %s expected %s got %s",
                     $time, replies_seen, what, exp_s, got_s);
    endfunction

    function void check_reply(logic [1:0] status, logic [31:0] word, logic kind,
                              logic [4:0] size, logic alarms);
        queue_reply_t e;
        replies_seen++;
        if (expected_replies.size() == 0) begin
            report("unexpected item", "none", $sformatf("status %0d", status));
            return;
        end
        e = expected_replies.pop_front();
        if (status !== e.status)
            report("status", $sformatf("%0d", e.status), $sformatf("%0d", status));
        if (word !== e.word)
            report("message_out", $sformatf("%08h", e.word), $sformatf("%08h", word));
        if (kind !== e.kind)
            report("kind_out", $sformatf("%0d", e.kind), $sformatf("%0d", kind));
        if (size !== e.size)
            report("queue_size", $sformatf("%0d", e.size), $sformatf("%0d", size));
        if (alarms !== e.alarms)
            report("alarm_count", $sformatf("%0d", e.alarms), $sformatf("%0d", alarms));
    endfunction
endclass

module testbench;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = apmq_pkg::OP_SEND;
    logic        s_msg_kind = apmq_pkg::MK_NORMAL;
    logic [31:0] s_message = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_message_out;
    logic        m_kind_out;
    logic [4:0]  m_queue_size;
    logic        m_alarm_count;

    alarm_queue_scoreboard sb = new;
    int cycle_count = 0;
    int ready_mode = 0;
    int stall_left = 0;

    alarm_priority_message_queue_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_msg_kind    (s_msg_kind),
        .s_message     (s_message),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_message_out (m_message_out),
        .m_kind_out    (m_kind_out),
        .m_queue_size  (m_queue_size),
        .m_alarm_count (m_alarm_count)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: switches between always ready, coin flips and long stalls
    always @(posedge aclk) begin
        if (cycle_count % 150 == 0) ready_mode <= $urandom_range(0, 2);
        case (ready_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                if (stall_left > 0) begin
                    m_ready <= 1'b0;
                    stall_left <= stall_left - 1;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 8);
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_reply(m_status, m_message_out, m_kind_out, m_queue_size, m_alarm_count);
    end

    // present one item and hold it until taken
    task automatic drive_item(logic kind, logic msg_kind, logic [31:0] message);
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_msg_kind <= msg_kind;
        s_message  <= message;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(kind, msg_kind, message);
    endtask

    task automatic drain_queue();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int sent;
        int burst;
        int gap;
        int send_pct;
        bit paused;
        logic op;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty receive, priority, refused alarm, full FIFO
        drive_item(apmq_pkg::OP_RECV, apmq_pkg::MK_NORMAL, 32'h0);
        drive_item(apmq_pkg::OP_SEND, apmq_pkg::MK_NORMAL, 32'h0000_0000);
        drive_item(apmq_pkg::OP_SEND, apmq_pkg::MK_ALARM,  32'hFFFF_FFFF);
        drive_item(apmq_pkg::OP_SEND, apmq_pkg::MK_ALARM,  32'h1234_5678);
        drive_item(apmq_pkg::OP_RECV, apmq_pkg::MK_NORMAL, 32'h0);
        drive_item(apmq_pkg::OP_RECV, apmq_pkg::MK_NORMAL, 32'h0);
        drive_item(apmq_pkg::OP_RECV, apmq_pkg::MK_ALARM,  32'hFFFF_FFFF);
        for (int i = 0; i < 16; i++)
            drive_item(apmq_pkg::OP_SEND, apmq_pkg::MK_NORMAL,
                       (i % 2) ? 32'hAAAA_AAAA ^ i : 32'h5555_5555 ^ i);
        drive_item(apmq_pkg::OP_SEND, apmq_pkg::MK_NORMAL, 32'hFFFF_FFFF);
        drive_item(apmq_pkg::OP_SEND, apmq_pkg::MK_ALARM,  32'h8000_0001);
        drain_queue();

        sent = 0;
        paused = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            case ($urandom_range(0, 2))
                0:       send_pct = 20;
                1:       send_pct = 50;
                default: send_pct = 85;
            endcase
            for (int i = 0; i < burst; i++) begin
                op = ($urandom_range(0, 99) < send_pct) ? apmq_pkg::OP_SEND
                                                          : apmq_pkg::OP_RECV;
                drive_item(op, ($urandom_range(0, 99) < 30) ? apmq_pkg::MK_ALARM
                                                             : apmq_pkg::MK_NORMAL,
                           pick_word());
                sent++;
            end
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                paused = 1;
                drain_queue();
            end else if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 6);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end

        drain_queue();
        repeat (10) @(posedge aclk);

        $display("covered %0d sends, %0d receives, %0d alarms taken, peak size %0d",
                 sb.sends, sb.receives, sb.alarms_taken, sb.peak_size);
        $display("refused: %0d alarm slot taken, %0d fifo full; %0d empty receives, %0d errors",
                 sb.alarm_refused, sb.full_refused, sb.empty_receives, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
